FILE: sv/ptq_pkg.sv
// shared types and constants for the periodic timer queue
package ptq_pkg;
	localparam int TaskSlots = 16;
	localparam int IdW = 32;
	localparam int PerW = 39;
	localparam int TimeW = 48;
	localparam logic [TimeW-1:0] TimeMax = '1;

	localparam logic [1:0] MODE_SET = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_TRIG = 2'd2;
	localparam logic [1:0] MODE_CLR = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_BADDLY = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	// one timer entry
	typedef struct packed {
		logic [IdW-1:0] id;
		logic [PerW-1:0] per;
		logic [TimeW-1:0] dl;
	} entry_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic ins;
		logic del_id;
		logic pop;
		logic clr;
		entry_t ent;
	} cell_cmd_t;

	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
			input logic [PerW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {{(TimeW+1-PerW){1'b0}}, b};
		return s[TimeW] ? TimeMax : s[TimeW-1:0];
	endfunction
endpackage

FILE: sv/ptq_cell.sv
// one cell of the sorted timer chain
module ptq_cell (
	input  logic clk,
	input  logic arst_n,
	input  ptq_pkg::cell_cmd_t cmd,
	input  logic left_valid,
	input  logic left_goes_after,
	input  logic left_hit,
	input  ptq_pkg::entry_t left_ent,
	input  logic right_valid,
	input  logic right_hit,
	input  ptq_pkg::entry_t right_ent,
	output logic valid,
	output logic goes_after,
	output logic hit,
	output ptq_pkg::entry_t ent
);
	import ptq_pkg::*;

	logic valid_q;
	entry_t ent_q;

	assign valid = valid_q;
	assign ent = ent_q;
	// new entry goes after this one (ties after equal deadlines)
	assign goes_after = valid_q && (ent_q.dl <= cmd.ent.dl);
	// this or an earlier cell matched the id being removed
	assign hit = left_hit || (valid_q && ent_q.id == cmd.ent.id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= valid_q || left_valid;
		end else if (cmd.del_id) begin
			if (hit)
				valid_q <= right_valid && right_hit;
		end else if (cmd.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!goes_after) begin
				if (left_goes_after)
					ent_q <= cmd.ent;
				else
					ent_q <= left_ent;
			end
		end else if ((cmd.del_id && hit) || cmd.pop) begin
			ent_q <= right_ent;
		end
	end
endmodule

FILE: sv/ptq_chain.sv
// row of timer cells with shift-left and shift-right neighbors
module ptq_chain #(
	parameter int Slots = ptq_pkg::TaskSlots
) (
	input  logic clk,
	input  logic arst_n,
	input  ptq_pkg::cell_cmd_t cmd,
	output logic found,
	output logic [Slots-1:0] due,
	output logic head_valid,
	output ptq_pkg::entry_t head
);
	import ptq_pkg::*;

	logic [Slots-1:0] v, ga, h;
	entry_t e [Slots];

	for (genvar g = 0; g < Slots; g++) begin : g_cell
		logic lv, lga, lh, rv, rh;
		entry_t le, re;
		if (g == 0) begin : g_first
			assign lv = 1'b1;
			assign lga = 1'b1;
			assign lh = 1'b0;
			assign le = cmd.ent;
		end else begin : g_mid
			assign lv = v[g-1];
			assign lga = ga[g-1];
			assign lh = h[g-1];
			assign le = e[g-1];
		end
		if (g == Slots-1) begin : g_last
			assign rv = 1'b0;
			assign rh = 1'b1;
			assign re = e[g];
		end else begin : g_inner
			assign rv = v[g+1];
			assign rh = 1'b1;
			assign re = e[g+1];
		end
		ptq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.left_valid(lv), .left_goes_after(lga), .left_hit(lh), .left_ent(le),
			.right_valid(rv), .right_hit(rh), .right_ent(re),
			.valid(v[g]), .goes_after(ga[g]), .hit(h[g]), .ent(e[g])
		);
	end

	assign found = h[Slots-1];
	// valid cells whose deadline is not after the broadcast deadline
	assign due = ga;
	assign head_valid = v[0];
	assign head = e[0];
endmodule

FILE: sv/periodic_timer_queue.sv
// top level of the periodic timer queue: command sequencer over the cell chain
// usage:
//   a request is taken when start is high and busy is low; its fields are
//   mode, task_id, period and now_time. busy stays high from the accepting
//   edge until the cycle in which the final result is shown, so the next
//   request can be taken at the edge that ends the summary.
//   results appear on the result ports for one cycle each, marked by
//   result_valid; kind 0 is a fired timer notice, kind 1 with last high the
//   final summary. the receiver cannot stall results.
//   set, delete and clear pass from the accepting edge through a lookup
//   state that also does any removal shift, an insertion state only for a
//   set that is taken, the summary state and the result cycle.
//   trigger runs the lookup state, then one pop and one sorted insertion
//   through the cell row per fired timer, each notice shown the cycle after
//   its insertion, then the summary state and the result cycle.
//   every cell compares its own deadline or id against a broadcast value,
//   so all cells of the row shift together in parallel.
//   reset empties the table and leaves the block idle.
module periodic_timer_queue #(
	parameter int TASK_SLOTS = ptq_pkg::TaskSlots
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] mode,
	input  logic [31:0] task_id,
	input  logic signed [39:0] period,
	input  logic [47:0] now_time,
	output logic result_valid,
	output logic kind,
	output logic [31:0] fired_id,
	output logic [47:0] next_delay,
	output logic [2:0] status,
	output logic [4:0] task_count,
	output logic [4:0] cleared_count,
	output logic last
);
	import ptq_pkg::*;

	localparam int CntW = $clog2(TASK_SLOTS + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_INS = 3'd2;
	localparam logic [2:0] S_TPOP = 3'd3;
	localparam logic [2:0] S_TINS = 3'd4;
	localparam logic [2:0] S_SUM = 3'd5;

	logic [2:0] state_q;
	logic [1:0] mode_q;
	logic [IdW-1:0] id_q;
	logic [39:0] per_q;
	logic [TimeW-1:0] now_q;
	logic [CntW-1:0] cnt_q, left_q;
	logic [2:0] st_q;
	logic [CntW-1:0] clr_q;
	entry_t hold_q;
	logic found;
	logic [TASK_SLOTS-1:0] due;
	logic head_valid;
	entry_t head;
	cell_cmd_t cmd;
	logic fire;

	function automatic logic [CntW-1:0] count_ones(input logic [TASK_SLOTS-1:0] m);
		logic [CntW-1:0] c;
		c = '0;
		for (int i = 0; i < TASK_SLOTS; i++)
			c = c + CntW'(m[i]);
		return c;
	endfunction

	ptq_chain #(.Slots(TASK_SLOTS)) u_chain (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.found(found), .due(due), .head_valid(head_valid), .head(head)
	);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.ent.id = id_q;
		cmd.ent.per = per_q[PerW-1:0];
		cmd.ent.dl = sat_add(now_q, per_q[PerW-1:0]);
		unique case (state_q)
			S_LOOK: begin
				if (mode_q == MODE_CLR)
					cmd.clr = 1'b1;
				else if (mode_q == MODE_TRIG)
					cmd.ent.dl = now_q;
				else if (!(mode_q == MODE_SET && per_q[39]))
					cmd.del_id = found;
			end
			S_INS: cmd.ins = 1'b1;
			S_TPOP: cmd.pop = fire;
			S_TINS: begin
				cmd.ins = 1'b1;
				cmd.ent.id = hold_q.id;
				cmd.ent.per = hold_q.per;
				cmd.ent.dl = sat_add(now_q, hold_q.per);
			end
			default: ;
		endcase
	end

	assign fire = head_valid && head.dl <= now_q && left_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			left_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_LOOK;
				S_LOOK: begin
					if (mode_q == MODE_CLR) begin
						cnt_q <= '0;
						state_q <= S_SUM;
					end else if (mode_q == MODE_TRIG) begin
						left_q <= count_ones(due);
						state_q <= S_TPOP;
					end else if (mode_q == MODE_SET && per_q[39]) begin
						state_q <= S_SUM;
					end else begin
						if (found) cnt_q <= cnt_q - 1'b1;
						if (mode_q == MODE_SET && (found || cnt_q != CntW'(TASK_SLOTS)))
							state_q <= S_INS;
						else
							state_q <= S_SUM;
					end
				end
				S_INS: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_SUM;
				end
				S_TPOP: begin
					if (fire) begin
						left_q <= left_q - 1'b1;
						state_q <= S_TINS;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_TINS: begin
					result_valid <= 1'b1;
					state_q <= S_TPOP;
				end
				S_SUM: begin
					result_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result registers; the chain pops only when the head fires
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode;
			id_q <= task_id;
			per_q <= period;
			now_q <= now_time;
			st_q <= ST_OK;
			clr_q <= '0;
		end
		if (state_q == S_LOOK) begin
			if (mode_q == MODE_CLR) begin
				clr_q <= cnt_q;
				st_q <= ST_EMPTY;
			end else if (mode_q == MODE_SET && per_q[39])
				st_q <= ST_BADDLY;
			else if (mode_q == MODE_DEL && !found)
				st_q <= ST_NOTFOUND;
			else if (mode_q == MODE_SET && !found && cnt_q == CntW'(TASK_SLOTS))
				st_q <= ST_FULL;
		end
		if (state_q == S_TPOP) hold_q <= head;
		kind <= (state_q == S_SUM);
		last <= (state_q == S_SUM);
		fired_id <= (state_q == S_TINS) ? hold_q.id : '0;
		cleared_count <= 5'(clr_q);
		task_count <= (state_q == S_TINS) ? 5'(cnt_q - left_q) : 5'(cnt_q);
		status <= ST_OK;
		next_delay <= '0;
		if (state_q == S_SUM) begin
			status <= (cnt_q == '0 && st_q == ST_OK) ? ST_EMPTY : st_q;
			if (cnt_q != '0 && st_q != ST_BADDLY && head.dl > now_q)
				next_delay <= head.dl - now_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) result_valid && last |-> !busy)
		else $error("summary shown while busy");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(TASK_SLOTS))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == S_TINS |=> result_valid && !kind)
		else $error("missing notice");
endmodule

FILE: tb/periodic_timer_queue_test.sv
// self-checking testbench for the periodic timer queue: directed and random requests
module periodic_timer_queue_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ptq_pkg::*;

	typedef struct {
		logic kind;
		logic [31:0] fired_id;
		logic [47:0] next_delay;
		logic [2:0] status;
		logic [4:0] task_count;
		logic [4:0] cleared_count;
		logic last;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = MODE_SET;
	logic [31:0] task_id = '0;
	logic signed [39:0] period = '0;
	logic [47:0] now_time = '0;
	logic result_valid, kind, last;
	logic [31:0] fired_id;
	logic [47:0] next_delay;
	logic [2:0] status;
	logic [4:0] task_count, cleared_count;

	timer_result_t pending_results[$];
	logic [31:0] tbl_id[TaskSlots];
	logic [38:0] tbl_per[TaskSlots];
	logic [47:0] tbl_dl[TaskSlots];
	int tbl_n = 0;
	int mismatches = 0;
	logic [47:0] clock_now = '0;
	int gap_left = 0;

	periodic_timer_queue u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("periodic_timer_queue: mismatch");
		$finish;
	end

	function automatic logic [47:0] deadline_of(logic [47:0] t, logic [38:0] p);
		logic [48:0] s;
		s = {1'b0, t} + {10'b0, p};
		return s[48] ? '1 : s[47:0];
	endfunction

	function automatic void tbl_remove(int p);
		for (int i = p; i + 1 < tbl_n; i++) begin
			tbl_id[i] = tbl_id[i+1];
			tbl_per[i] = tbl_per[i+1];
			tbl_dl[i] = tbl_dl[i+1];
		end
		tbl_n--;
	endfunction

	function automatic void tbl_insert(logic [31:0] id, logic [38:0] p, logic [47:0] dl);
		int pos;
		pos = 0;
		while (pos < tbl_n && tbl_dl[pos] <= dl) pos++;
		for (int i = tbl_n; i > pos; i--) begin
			tbl_id[i] = tbl_id[i-1];
			tbl_per[i] = tbl_per[i-1];
			tbl_dl[i] = tbl_dl[i-1];
		end
		tbl_id[pos] = id;
		tbl_per[pos] = p;
		tbl_dl[pos] = dl;
		tbl_n++;
	endfunction

	function automatic int tbl_find(logic [31:0] id);
		for (int i = 0; i < tbl_n; i++)
			if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic void predict_timers(logic [1:0] m, logic [31:0] id,
			logic [39:0] p, logic [47:0] t);
		timer_result_t r;
		logic [2:0] st;
		logic [4:0] cc;
		logic use_delay;
		int k, f;
		logic [31:0] fid[TaskSlots];
		logic [38:0] fper[TaskSlots];
		st = ST_OK;
		cc = '0;
		use_delay = 1'b1;
		case (m)
			MODE_SET: begin
				if (p[39]) begin
					st = ST_BADDLY;
					use_delay = 1'b0;
				end else begin
					f = tbl_find(id);
					if (f >= 0) tbl_remove(f);
					if (tbl_n >= TaskSlots) st = ST_FULL;
					else tbl_insert(id, p[38:0], deadline_of(t, p[38:0]));
				end
			end
			MODE_DEL: begin
				f = tbl_find(id);
				if (f >= 0) tbl_remove(f);
				else st = ST_NOTFOUND;
			end
			MODE_TRIG: begin
				k = 0;
				while (k < tbl_n && tbl_dl[k] <= t) begin
					fid[k] = tbl_id[k];
					fper[k] = tbl_per[k];
					k++;
				end
				for (int i = 0; i < k; i++) tbl_remove(0);
				for (int i = 0; i < k; i++) begin
					tbl_insert(fid[i], fper[i], deadline_of(t, fper[i]));
					r = '{1'b0, fid[i], 48'd0, ST_OK, 5'(tbl_n), 5'd0, 1'b0};
					pending_results.insert(pending_results.size(), r);
				end
			end
			default: begin
				cc = 5'(tbl_n);
				tbl_n = 0;
			end
		endcase
		r = '{1'b1, 32'd0, 48'd0, st, 5'(tbl_n), cc, 1'b1};
		if (tbl_n == 0) begin
			if (st == ST_OK) r.status = ST_EMPTY;
		end else if (use_delay) begin
			r.next_delay = tbl_dl[0] > t ? tbl_dl[0] - t : '0;
		end
		pending_results.insert(pending_results.size(), r);
	endfunction

	always @(posedge clk) begin
		timer_result_t e;
		if (result_valid) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result id %h", fired_id);
			end else begin
				e = pending_results.pop_front();
				if (kind !== e.kind || fired_id !== e.fired_id || next_delay !== e.next_delay
						|| status !== e.status || task_count !== e.task_count
						|| cleared_count !== e.cleared_count || last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp %h %h %h %h %h %h %h got %h %h %h %h %h %h %h",
							e.kind, e.fired_id, e.next_delay, e.status, e.task_count,
							e.cleared_count, e.last, kind, fired_id, next_delay, status,
							task_count, cleared_count, last);
				end
			end
		end
	end

	task automatic send_request(logic [1:0] m, logic [31:0] id, logic [39:0] p,
			logic [47:0] t);
		if (gap_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			gap_left = $urandom_range(1, 12);
		end
		gap_left--;
		mode <= m;
		task_id <= id;
		period <= p;
		now_time <= t;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_timers(m, id, p, t);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic test_directed();
		send_request(MODE_TRIG, 32'd0, 40'd0, 48'd0);
		send_request(MODE_DEL, 32'd5, 40'd0, 48'd0);
		send_request(MODE_SET, 32'd1, 40'h80_0000_0000, 48'd10);
		send_request(MODE_SET, 32'hFFFF_FFFF, 40'h7F_FFFF_FFFF, '1);
		send_request(MODE_SET, 32'd0, 40'd0, 48'd100);
		send_request(MODE_SET, 32'd2, 40'd0, 48'd100);
		send_request(MODE_SET, 32'd2, 40'd50, 48'd100);
		send_request(MODE_TRIG, 32'd0, 40'd0, 48'd100);
		send_request(MODE_TRIG, 32'd0, 40'd0, 48'd200);
		send_request(MODE_DEL, 32'd0, 40'd0, 48'd200);
		send_request(MODE_DEL, 32'd77, 40'd0, 48'd200);
		for (int i = 0; i < 17; i++)
			send_request(MODE_SET, 32'(i + 10), 40'(i % 3), 48'd300);
		send_request(MODE_TRIG, 32'd0, 40'd0, 48'd400);
		send_request(MODE_CLR, 32'd0, 40'd0, 48'd400);
		send_request(MODE_CLR, 32'd0, 40'd0, 48'd400);
		drain_results();
	endtask

	task automatic test_random();
		logic [1:0] m;
		logic [39:0] p;
		logic [31:0] id;
		for (int n = 0; n < 180; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: m = MODE_SET;
				8, 9, 10: m = MODE_DEL;
				19: m = MODE_CLR;
				default: m = MODE_TRIG;
			endcase
			id = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 20));
			case ($urandom_range(0, 9))
				0: p = 40'({$urandom, $urandom}) | 40'h80_0000_0000;
				1: p = {1'b0, 7'($urandom), $urandom};
				2: p = '0;
				default: p = 40'($urandom_range(0, 200));
			endcase
			if ($urandom_range(0, 30) == 0) clock_now = '1 - 48'($urandom_range(0, 100));
			else if ($urandom_range(0, 30) == 0) clock_now = 48'({$urandom, $urandom});
			else clock_now = clock_now + 48'($urandom_range(0, 60));
			send_request(m, id, p, clock_now);
			if (n == 90) drain_results();
		end
		drain_results();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("periodic_timer_queue: match");
		else
			$display("periodic_timer_queue: mismatch");
		$finish;
	end
endmodule

FILE: files.f
sv/ptq_pkg.sv
sv/ptq_cell.sv
sv/ptq_chain.sv
sv/periodic_timer_queue.sv
tb/periodic_timer_queue_test.sv
